// ===== design/address_blacklist_table_assert.svh =====
//------------------------------------------------------------------------------
// Address blacklist table assertion macros
// Shared concurrent assertion forms used by the table control logic.
//------------------------------------------------------------------------------
`ifndef ADDRESS_BLACKLIST_TABLE_ASSERT_SVH
`define ADDRESS_BLACKLIST_TABLE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define ABT_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("address blacklist table: assertion failed");

// Condition must hold in the cycle after the trigger.
`define ABT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("address blacklist table: assertion failed");

`endif

// ===== design/abt_pkg.sv =====
//------------------------------------------------------------------------------
// Address blacklist table package
// Sizes, command and result codes, and the control bundle sent to the cells.
//------------------------------------------------------------------------------
package abt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int DOMAIN_BITS   = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 32;
    localparam int DOM_IN_W = 16;
    localparam int RES_W    = 2;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

    localparam logic [RES_W-1:0] RES_ABSENT  = 2'd0;
    localparam logic [RES_W-1:0] RES_DONE    = 2'd1;
    localparam logic [RES_W-1:0] RES_PRESENT = 2'd2;
    localparam logic [RES_W-1:0] RES_FULL    = 2'd3;

    typedef struct packed {
        logic             cmp_en;
        logic             add_en;
        logic             rem_en;
        logic [IDX_W-1:0] rem_idx;
    } t_cell_ctl;

endpackage

// ===== design/abt_if.sv =====
//------------------------------------------------------------------------------
// Address blacklist table channels
// Request and response channels with a valid/ready handshake.
//------------------------------------------------------------------------------
interface abt_in_if;
    logic                         valid;
    logic                         ready;
    logic [abt_pkg::CMD_W-1:0]    cmd;
    logic [abt_pkg::ADDR_W-1:0]   ip_addr;
    logic [abt_pkg::DOM_IN_W-1:0] domain_id;

    modport source (output valid, output cmd, output ip_addr, output domain_id,
                    input ready);
    modport sink   (input valid, input cmd, input ip_addr, input domain_id,
                    output ready);
endinterface

interface abt_out_if;
    logic                        valid;
    logic                        ready;
    logic [abt_pkg::RES_W-1:0]   outcome;
    logic [abt_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, output outcome, output entry_count, input ready);
    modport sink   (input valid, input outcome, input entry_count, output ready);
endinterface

// ===== design/address_blacklist_table.sv =====
//------------------------------------------------------------------------------
// Address blacklist table
// Ordered table of banned (address, domain) pairs with add, remove and check.
//------------------------------------------------------------------------------
// Each command passes through acceptance, a compare in every table cell, a
// reduction of the cell match flags to a hit and a position, and the update,
// which loads the response register and shifts the cells behind a removed
// entry one place toward the head. The next command is accepted in the cycle
// after the update, so the block takes no new command before the last one is
// through; a response that waits holds back only the update step.
// Domain 0 is the wildcard. The table resets empty; no clearing pass is needed.
module address_blacklist_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    abt_in_if.sink    i_in,
    abt_out_if.source o_out
);

    abt_pkg::t_cell_ctl                  w_ctl;
    logic [abt_pkg::CNT_W-1:0]           w_fill;
    logic [abt_pkg::ADDR_W-1:0]          w_q_addr;
    logic [abt_pkg::DOMAIN_BITS-1:0]     w_q_dom;
    logic [abt_pkg::TABLE_ENTRIES-1:0]   w_exact;
    logic [abt_pkg::TABLE_ENTRIES-1:0]   w_hit;
    logic [abt_pkg::ADDR_W-1:0]          w_addr [abt_pkg::TABLE_ENTRIES];
    logic [abt_pkg::DOMAIN_BITS-1:0]     w_dom  [abt_pkg::TABLE_ENTRIES];

    abt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_exact  (w_exact),
        .i_hit    (w_hit),
        .o_ctl    (w_ctl),
        .o_fill   (w_fill),
        .o_q_addr (w_q_addr),
        .o_q_dom  (w_q_dom)
    );

    for (genvar g = 0; g < abt_pkg::TABLE_ENTRIES; g++) begin : g_cell
        logic [abt_pkg::ADDR_W-1:0]      w_next_addr;
        logic [abt_pkg::DOMAIN_BITS-1:0] w_next_dom;

        // The last cell has no neighbor; what it takes on a removal lies
        // beyond the fill level and is never read.
        if (g == abt_pkg::TABLE_ENTRIES - 1) begin : g_tail
            assign w_next_addr = w_addr[g];
            assign w_next_dom  = w_dom[g];
        end else begin : g_body
            assign w_next_addr = w_addr[g+1];
            assign w_next_dom  = w_dom[g+1];
        end

        abt_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (abt_pkg::IDX_W'(g)),
            .i_fill      (w_fill),
            .i_ctl       (w_ctl),
            .i_q_addr    (w_q_addr),
            .i_q_dom     (w_q_dom),
            .i_next_addr (w_next_addr),
            .i_next_dom  (w_next_dom),
            .o_addr      (w_addr[g]),
            .o_dom       (w_dom[g]),
            .o_exact     (w_exact[g]),
            .o_hit       (w_hit[g])
        );
    end

endmodule

// ===== design/abt_cell.sv =====
//------------------------------------------------------------------------------
// Address blacklist table cell
// Holds one (address, domain) entry, compares it against the query and takes
// its neighbor's entry when a removal closes the gap.
//------------------------------------------------------------------------------
module abt_cell (
    input  logic                            i_clk,
    input  logic [abt_pkg::IDX_W-1:0]       i_index,
    input  logic [abt_pkg::CNT_W-1:0]       i_fill,
    input  abt_pkg::t_cell_ctl              i_ctl,
    input  logic [abt_pkg::ADDR_W-1:0]      i_q_addr,
    input  logic [abt_pkg::DOMAIN_BITS-1:0] i_q_dom,
    input  logic [abt_pkg::ADDR_W-1:0]      i_next_addr,
    input  logic [abt_pkg::DOMAIN_BITS-1:0] i_next_dom,
    output logic [abt_pkg::ADDR_W-1:0]      o_addr,
    output logic [abt_pkg::DOMAIN_BITS-1:0] o_dom,
    output logic                            o_exact,
    output logic                            o_hit
);

    logic [abt_pkg::ADDR_W-1:0]      r_addr;
    logic [abt_pkg::DOMAIN_BITS-1:0] r_dom;
    logic                            r_exact;
    logic                            r_hit;
    logic                            w_held;
    logic                            w_addr_eq;

    // An entry is meaningful only below the fill level.
    assign w_held    = {1'b0, i_index} < abt_pkg::CNT_W'(i_fill);
    assign w_addr_eq = (r_addr == i_q_addr);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_exact <= w_held && w_addr_eq && (r_dom == i_q_dom);
            r_hit   <= w_held && w_addr_eq && ((r_dom == '0) || (r_dom == i_q_dom));
        end
        if (i_ctl.add_en && (i_index == i_fill[abt_pkg::IDX_W-1:0])) begin
            r_addr <= i_q_addr;
            r_dom  <= i_q_dom;
        end else if (i_ctl.rem_en && (i_index >= i_ctl.rem_idx)) begin
            r_addr <= i_next_addr;
            r_dom  <= i_next_dom;
        end
    end

    assign o_addr  = r_addr;
    assign o_dom   = r_dom;
    assign o_exact = r_exact;
    assign o_hit   = r_hit;

endmodule

// ===== design/abt_ctrl.sv =====
//------------------------------------------------------------------------------
// Address blacklist table control
// Sequences each command through compare, match reduction and update, keeps
// the fill level and holds the response register.
//------------------------------------------------------------------------------
`include "address_blacklist_table_assert.svh"

module abt_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    abt_in_if.sink                              i_in,
    abt_out_if.source                           o_out,
    input  logic [abt_pkg::TABLE_ENTRIES-1:0]   i_exact,
    input  logic [abt_pkg::TABLE_ENTRIES-1:0]   i_hit,
    output abt_pkg::t_cell_ctl                  o_ctl,
    output logic [abt_pkg::CNT_W-1:0]           o_fill,
    output logic [abt_pkg::ADDR_W-1:0]          o_q_addr,
    output logic [abt_pkg::DOMAIN_BITS-1:0]     o_q_dom
);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_FIND, S_APPLY} t_state;

    t_state                          r_state, n_state;
    logic [abt_pkg::CMD_W-1:0]       r_cmd, n_cmd;
    logic [abt_pkg::ADDR_W-1:0]      r_addr, n_addr;
    logic [abt_pkg::DOMAIN_BITS-1:0] r_dom, n_dom;
    logic [abt_pkg::CNT_W-1:0]       r_fill, n_fill;
    logic                            r_any_exact, n_any_exact;
    logic                            r_any_hit, n_any_hit;
    logic [abt_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic                            r_out_valid, n_out_valid;
    logic [abt_pkg::RES_W-1:0]       r_outcome, n_outcome;
    logic [abt_pkg::COUNT_W-1:0]     r_count, n_count;

    logic w_out_take;
    logic w_out_free;
    logic w_full;
    logic w_add_en;
    logic w_rem_en;

    assign w_out_take = r_out_valid && o_out.ready;
    assign w_out_free = !r_out_valid || w_out_take;
    assign w_full     = (r_fill == abt_pkg::CNT_W'(abt_pkg::TABLE_ENTRIES));
    assign w_add_en   = (r_state == S_APPLY) && w_out_free && (r_cmd == abt_pkg::CMD_ADD)
                        && !w_full && !r_any_exact;
    assign w_rem_en   = (r_state == S_APPLY) && w_out_free
                        && (r_cmd == abt_pkg::CMD_REMOVE) && r_any_exact;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_dom       = r_dom;
        n_fill      = r_fill;
        n_any_exact = r_any_exact;
        n_any_hit   = r_any_hit;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !w_out_take;
        n_outcome   = r_outcome;
        n_count     = r_count;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = i_in.cmd;
                    n_addr  = i_in.ip_addr;
                    n_dom   = i_in.domain_id[abt_pkg::DOMAIN_BITS-1:0];
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_FIND;
            end
            S_FIND: begin
                // Held pairs are unique, so at most one exact flag is set and
                // OR-ing the indexes of set flags yields its position.
                n_any_exact = |i_exact;
                n_any_hit   = |i_hit;
                n_idx       = '0;
                for (int i = 0; i < abt_pkg::TABLE_ENTRIES; i++) begin
                    if (i_exact[i]) begin
                        n_idx = n_idx | abt_pkg::IDX_W'(i);
                    end
                end
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_outcome = abt_pkg::RES_ABSENT;
                    case (r_cmd)
                        abt_pkg::CMD_ADD: begin
                            if (w_full) begin
                                n_outcome = abt_pkg::RES_FULL;
                            end else if (r_any_exact) begin
                                n_outcome = abt_pkg::RES_PRESENT;
                            end else begin
                                n_outcome = abt_pkg::RES_DONE;
                                n_fill    = r_fill + 1'b1;
                            end
                        end
                        abt_pkg::CMD_REMOVE: begin
                            if (r_any_exact) begin
                                n_outcome = abt_pkg::RES_DONE;
                                n_fill    = r_fill - 1'b1;
                            end
                        end
                        abt_pkg::CMD_CHECK: begin
                            if (r_any_hit) begin
                                n_outcome = abt_pkg::RES_DONE;
                            end
                        end
                        default: begin
                            n_outcome = abt_pkg::RES_ABSENT;
                        end
                    endcase
                    n_count     = abt_pkg::COUNT_W'(n_fill);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_addr      <= n_addr;
        r_dom       <= n_dom;
        r_any_exact <= n_any_exact;
        r_any_hit   <= n_any_hit;
        r_idx       <= n_idx;
        r_outcome   <= n_outcome;
        r_count     <= n_count;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.outcome     = r_outcome;
    assign o_out.entry_count = r_count;

    assign o_ctl.cmp_en  = (r_state == S_CMP);
    assign o_ctl.add_en  = w_add_en;
    assign o_ctl.rem_en  = w_rem_en;
    assign o_ctl.rem_idx = r_idx;
    assign o_fill        = r_fill;
    assign o_q_addr      = r_addr;
    assign o_q_dom       = r_dom;

    `ABT_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= abt_pkg::CNT_W'(abt_pkg::TABLE_ENTRIES))
    `ABT_ASSERT_SAME(a_exact_unique, i_clk, i_rst_n, r_state == S_FIND, $onehot0(i_exact))
    `ABT_ASSERT_NEXT(a_fill_only_on_apply, i_clk, i_rst_n, r_state != S_APPLY, $stable(r_fill))
    `ABT_ASSERT_NEXT(a_add_grows, i_clk, i_rst_n, w_add_en, r_fill == $past(r_fill) + 1'b1)
    `ABT_ASSERT_NEXT(a_rem_shrinks, i_clk, i_rst_n, w_rem_en, r_fill == $past(r_fill) - 1'b1)

endmodule

// ===== tb/tb_address_blacklist_table.sv =====
//------------------------------------------------------------------------------
// Address blacklist table testbench
// Runs a directed table of commands and then random phases through the table.
// The phases flood it to full, fill it, drain it and mix the commands. Both
// channels idle at random. A local ban list model predicts untyped responses.
//------------------------------------------------------------------------------
module tb_address_blacklist_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [abt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1850;
    localparam int ADDR_POOL    = 20;
    localparam int DOM_POOL     = 4;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_DIRECTED   = 20;

    typedef enum int {PH_FLOOD, PH_FILL, PH_DRAIN, PH_BLEND} t_phase_kind;

    typedef struct {
        logic [abt_pkg::RES_W-1:0]   outcome;
        logic [abt_pkg::COUNT_W-1:0] count;
    } t_verdict;

    // A directed row with typed = 1 carries its response. Otherwise the
    // ban list model supplies it.
    typedef struct {
        logic [abt_pkg::CMD_W-1:0]    cmd;
        logic [abt_pkg::ADDR_W-1:0]   addr;
        logic [abt_pkg::DOM_IN_W-1:0] dom;
        bit                           typed;
        logic [abt_pkg::RES_W-1:0]    outcome;
        logic [abt_pkg::COUNT_W-1:0]  count;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    abt_in_if  req_if ();
    abt_out_if rsp_if ();

    address_blacklist_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // Local copy of the ban list, in arrival order.
    logic [abt_pkg::ADDR_W-1:0]      ban_addr [abt_pkg::TABLE_ENTRIES];
    logic [abt_pkg::DOMAIN_BITS-1:0] ban_dom  [abt_pkg::TABLE_ENTRIES];
    int                              ban_count;

    t_verdict pending_verdicts[$];

    logic [abt_pkg::ADDR_W-1:0]   addr_pool [ADDR_POOL];
    logic [abt_pkg::DOM_IN_W-1:0] dom_pool  [DOM_POOL];

    int errors;
    bit no_idle;
    bit hold_rsp;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{abt_pkg::CMD_CHECK,  32'h0000_0000, 16'h0000, 1'b1, abt_pkg::RES_ABSENT,  7'd0},
        '{abt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, abt_pkg::RES_ABSENT,  7'd0},
        '{abt_pkg::CMD_ADD,    32'h0000_0000, 16'h0000, 1'b1, abt_pkg::RES_DONE,    7'd1},
        '{abt_pkg::CMD_ADD,    32'h0000_0000, 16'h0000, 1'b1, abt_pkg::RES_PRESENT, 7'd1},
        '{abt_pkg::CMD_ADD,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, abt_pkg::RES_DONE,    7'd2},
        '{abt_pkg::CMD_ADD,    32'hFFFF_FFFF, 16'h0000, 1'b1, abt_pkg::RES_DONE,    7'd3},
        '{abt_pkg::CMD_CHECK,  32'h0000_0000, 16'h1234, 1'b1, abt_pkg::RES_DONE,    7'd3},
        '{abt_pkg::CMD_CHECK,  32'hFFFF_FFFF, 16'h0000, 1'b1, abt_pkg::RES_DONE,    7'd3},
        '{abt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b1, abt_pkg::RES_DONE,    7'd2},
        '{abt_pkg::CMD_CHECK,  32'hFFFF_FFFF, 16'h0000, 1'b1, abt_pkg::RES_ABSENT,  7'd2},
        '{abt_pkg::CMD_CHECK,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, abt_pkg::RES_DONE,    7'd2},
        '{abt_pkg::CMD_CHECK,  32'hFFFF_FFFF, 16'hFFFE, 1'b1, abt_pkg::RES_ABSENT,  7'd2},
        '{CMD_UNUSED,          32'h0000_0000, 16'h0000, 1'b1, abt_pkg::RES_ABSENT,  7'd2},
        '{abt_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0005, 1'b1, abt_pkg::RES_ABSENT,  7'd2},
        '{abt_pkg::CMD_ADD,    32'hA5A5_A5A5, 16'h5A5A, 1'b0, abt_pkg::RES_ABSENT,  7'd0},
        '{abt_pkg::CMD_ADD,    32'h5A5A_5A5A, 16'hA5A5, 1'b0, abt_pkg::RES_ABSENT,  7'd0},
        '{abt_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, abt_pkg::RES_ABSENT,  7'd0},
        '{abt_pkg::CMD_CHECK,  32'hA5A5_A5A5, 16'h1111, 1'b0, abt_pkg::RES_ABSENT,  7'd0},
        '{abt_pkg::CMD_CHECK,  32'h5A5A_5A5A, 16'hA5A5, 1'b0, abt_pkg::RES_ABSENT,  7'd0},
        '{abt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, abt_pkg::RES_ABSENT,  7'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Applies one command to the local ban list and returns the response.
    function automatic void ban_list_apply(input logic [abt_pkg::CMD_W-1:0] cmd,
                                           input logic [abt_pkg::ADDR_W-1:0] addr,
                                           input logic [abt_pkg::DOM_IN_W-1:0] dom_in,
                                           output logic [abt_pkg::RES_W-1:0] outcome,
                                           output logic [abt_pkg::COUNT_W-1:0] count);
        logic [abt_pkg::DOMAIN_BITS-1:0] dom;
        int pos;
        dom = abt_pkg::DOMAIN_BITS'(dom_in);
        outcome = abt_pkg::RES_ABSENT;
        pos = ban_count;
        for (int i = ban_count - 1; i >= 0; i--) begin
            if (ban_addr[i] == addr && ban_dom[i] == dom) pos = i;
        end
        case (cmd)
            abt_pkg::CMD_ADD: begin
                // Fullness wins over the duplicate search.
                if (ban_count >= abt_pkg::TABLE_ENTRIES) begin
                    outcome = abt_pkg::RES_FULL;
                end else if (pos < ban_count) begin
                    outcome = abt_pkg::RES_PRESENT;
                end else begin
                    ban_addr[ban_count] = addr;
                    ban_dom[ban_count]  = dom;
                    ban_count++;
                    outcome = abt_pkg::RES_DONE;
                end
            end
            abt_pkg::CMD_REMOVE: begin
                if (pos < ban_count) begin
                    for (int i = pos; i + 1 < ban_count; i++) begin
                        ban_addr[i] = ban_addr[i + 1];
                        ban_dom[i]  = ban_dom[i + 1];
                    end
                    ban_count--;
                    outcome = abt_pkg::RES_DONE;
                end
            end
            abt_pkg::CMD_CHECK: begin
                for (int i = 0; i < ban_count; i++) begin
                    if (ban_addr[i] == addr && (ban_dom[i] == '0 || ban_dom[i] == dom))
                        outcome = abt_pkg::RES_DONE;
                end
            end
            default: ;
        endcase
        count = abt_pkg::COUNT_W'(ban_count);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void refresh_pools();
        int r;
        for (int i = 0; i < ADDR_POOL; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)      addr_pool[i] = '0;
            else if (r == 1) addr_pool[i] = '1;
            else             addr_pool[i] = $urandom;
        end
        dom_pool[0] = '0;
        for (int i = 1; i < DOM_POOL; i++) begin
            dom_pool[i] = ($urandom_range(0, 5) == 0) ? '1 : abt_pkg::DOM_IN_W'($urandom);
        end
    endfunction

    // Draws one command for the given phase, aiming removes and checks
    // mostly at pairs that are held.
    function automatic void make_command(input t_phase_kind kind,
                                         output logic [abt_pkg::CMD_W-1:0] cmd,
                                         output logic [abt_pkg::ADDR_W-1:0] addr,
                                         output logic [abt_pkg::DOM_IN_W-1:0] dom);
        int add_pct;
        int rem_pct;
        int r;
        int idx;
        addr = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
        dom  = dom_pool[$urandom_range(0, DOM_POOL - 1)];
        case (kind)
            PH_FLOOD: begin add_pct = 90; rem_pct = 0;  end
            PH_FILL:  begin add_pct = 70; rem_pct = 10; end
            PH_DRAIN: begin add_pct = 10; rem_pct = 65; end
            default:  begin add_pct = 35; rem_pct = 30; end
        endcase
        idx = (ban_count > 0) ? $urandom_range(0, ban_count - 1) : 0;
        if ($urandom_range(0, 99) < 4) begin
            cmd  = abt_pkg::CMD_W'($urandom_range(0, 3));
            addr = $urandom;
            dom  = abt_pkg::DOM_IN_W'($urandom);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
            cmd = abt_pkg::CMD_ADD;
            if (kind == PH_FLOOD) begin
                addr = $urandom;
                dom  = ($urandom_range(0, 3) == 0) ? '0 : abt_pkg::DOM_IN_W'($urandom);
            end else if (ban_count > 0 && $urandom_range(0, 4) == 0) begin
                addr = ban_addr[idx];
                dom  = abt_pkg::DOM_IN_W'(ban_dom[idx]);
            end
        end else if (r < add_pct + rem_pct) begin
            cmd = abt_pkg::CMD_REMOVE;
            if (ban_count > 0 && $urandom_range(0, 9) < 7) begin
                addr = ban_addr[idx];
                dom  = abt_pkg::DOM_IN_W'(ban_dom[idx]);
            end
        end else begin
            cmd = abt_pkg::CMD_CHECK;
            if (ban_count > 0 && $urandom_range(0, 9) < 6) begin
                addr = ban_addr[idx];
                case ($urandom_range(0, 2))
                    0:       dom = abt_pkg::DOM_IN_W'(ban_dom[idx]);
                    1:       dom = '0;
                    default: ;
                endcase
            end
        end
    endfunction

    // Offers one transaction, waits for it to be taken and queues its response.
    task automatic send_command(input logic [abt_pkg::CMD_W-1:0] cmd,
                                input logic [abt_pkg::ADDR_W-1:0] addr,
                                input logic [abt_pkg::DOM_IN_W-1:0] dom,
                                input bit typed,
                                input logic [abt_pkg::RES_W-1:0] typed_outcome,
                                input logic [abt_pkg::COUNT_W-1:0] typed_count);
        int gap;
        t_verdict v;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= cmd;
        req_if.ip_addr   <= addr;
        req_if.domain_id <= dom;
        do @(posedge i_clk); while (!req_if.ready);
        ban_list_apply(cmd, addr, dom, v.outcome, v.count);
        if (typed) begin
            v.outcome = typed_outcome;
            v.count   = typed_count;
        end
        pending_verdicts.push_back(v);
    endtask

    // Sender and end of run.
    initial begin
        logic [abt_pkg::CMD_W-1:0]    cmd;
        logic [abt_pkg::ADDR_W-1:0]   addr;
        logic [abt_pkg::DOM_IN_W-1:0] dom;
        t_phase_kind kind;
        int sent;
        int phase;
        int phase_len;

        errors    = 0;
        ban_count = 0;
        no_idle   = 1'b0;
        hold_rsp  = 1'b0;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.cmd       <= abt_pkg::CMD_ADD;
        req_if.ip_addr   <= '0;
        req_if.domain_id <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].dom,
                         directed_rows[i].typed, directed_rows[i].outcome,
                         directed_rows[i].count);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            refresh_pools();
            kind      = (phase == 0) ? PH_FLOOD : t_phase_kind'($urandom_range(0, 3));
            phase_len = $urandom_range(40, 120);
            no_idle   = ($urandom_range(0, 4) == 0);
            // Hold the response side off while commands keep coming.
            if (phase % 8 == 3) hold_rsp = 1'b1;
            // Let the block run dry before this phase starts.
            if (phase % 9 == 6) begin
                req_if.valid <= 1'b0;
                while (pending_verdicts.size() != 0) @(posedge i_clk);
            end
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                make_command(kind, cmd, addr, dom);
                send_command(cmd, addr, dom, 1'b0, abt_pkg::RES_ABSENT, '0);
                if (cmd != CMD_UNUSED) sent++;
            end
            phase++;
        end
        req_if.valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: random ready with stalls, and the long hold when asked.
    initial begin
        int stall_left;
        t_verdict v;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected response: outcome %0d, entry_count %0d",
                           rsp_if.outcome, rsp_if.entry_count);
                    errors++;
                end else begin
                    v = pending_verdicts.pop_front();
                    if (rsp_if.outcome !== v.outcome) begin
                        $error("outcome mismatch: expected %0d, actual %0d",
                               v.outcome, rsp_if.outcome);
                        errors++;
                    end
                    if (rsp_if.entry_count !== v.count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               v.count, rsp_if.entry_count);
                        errors++;
                    end
                end
            end
            if (hold_rsp) begin
                hold_rsp   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (no_idle || $urandom_range(0, 9) < 7) begin
                rsp_if.ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                rsp_if.ready <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which neither channel completes a transaction.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/abt_pkg.sv
design/abt_if.sv
design/abt_cell.sv
design/abt_ctrl.sv
design/address_blacklist_table.sv
tb/tb_address_blacklist_table.sv
